// ----- rtl/line_log_ring_buffer_core_macros.svh -----
// Assertion macros shared by the line log ring buffer RTL.
`ifndef LINE_LOG_RING_BUFFER_CORE_MACROS_SVH
`define LINE_LOG_RING_BUFFER_CORE_MACROS_SVH

// Clocking and reset qualification used by every check.
`define LLRB_CLK_RST @(posedge clk) disable iff (!rst_n)

// Overlapping implication check with a labelled error report.
`define LLRB_CHECK(lbl, ant, cons, msg) \
  lbl: assert property (`LLRB_CLK_RST (ant) |-> (cons)) else $error(msg);

`endif

// ----- rtl/llrb_pkg.sv -----
// Package with the constants, codes and types of the line log ring buffer.
`timescale 1ns / 1ps
package llrb_pkg;

  localparam int LOG_SIZE    = 2048;
  localparam int NUM_READERS = 4;
  localparam int MAX_READ    = 64;
  localparam int ADDR_W      = $clog2(LOG_SIZE);
  localparam int SLOT_W      = (NUM_READERS > 1) ? $clog2(NUM_READERS) : 1;
  localparam int CNT_W       = 32;
  localparam int LEN_W       = 7;

  localparam logic [7:0] NL  = 8'h0A;
  localparam logic [7:0] NUL = 8'h00;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_OPEN  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLOSE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STS_OK           = 3'd0,
    STS_LOST         = 3'd1,
    STS_EMPTY        = 3'd2,
    STS_NO_READER    = 3'd3,
    STS_ALREADY_OPEN = 3'd4
  } sts_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DISPATCH,
    BK_EVICT_RD,
    BK_EVICT_CHK,
    BK_RD_ISSUE,
    BK_RD_DATA,
    BK_EMIT_NL,
    BK_RESULT
  } bk_state_e;

  typedef struct packed {
    op_e              op;
    logic [7:0]       data;
    logic [1:0]       reader;
    logic             slot_bad;
    logic [LEN_W-1:0] limit;
  } cmd_t;

endpackage

// ----- rtl/llrb_in_if.sv -----
// Input channel interface carrying one command item.
`timescale 1ns / 1ps
interface llrb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] data_byte;
  logic [1:0] reader;
  logic [6:0] max_len;

  modport source (output valid, operation, data_byte, reader, max_len, input ready);
  modport sink   (input valid, operation, data_byte, reader, max_len, output ready);
endinterface

// ----- rtl/llrb_out_if.sv -----
// Result channel interface carrying one result item.
`timescale 1ns / 1ps
interface llrb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       has_byte;
  logic       last;

  modport source (output valid, out_byte, status, has_byte, last, input ready);
  modport sink   (input valid, out_byte, status, has_byte, last, output ready);
endinterface

// ----- rtl/line_log_ring_buffer_core.sv -----
// Top level of the line log ring buffer: front end, command queue and back end.
//
//   channel   direction  handshake      payload
//   in_itm    in         valid / ready  operation, data_byte, reader, max_len
//   out_itm   out        valid / ready  out_byte, status, has_byte, last
//
// A two-entry queue holds accepted items while the back end works on one at a time.
// Open, close, failed reads and writes without eviction pass through dispatch and result states.
// A write that fills the ring then reads and checks each evicted byte in turn (store read latency).
// A read line fetches each returned byte through the store read port before it is emitted.
// Reset is synchronous and clears counts, reader state and handshakes; store needs none.
// A stalled result holds the back end; the queue keeps accepting until it is full.
`timescale 1ns / 1ps
`include "line_log_ring_buffer_core_macros.svh"
module line_log_ring_buffer_core (
  input  logic        clk,
  input  logic        rst_n,
  llrb_in_if.sink     in_itm,
  llrb_out_if.source  out_itm
);
  import llrb_pkg::*;

  cmd_t q_cmd;
  logic q_valid;
  logic q_pop;

  llrb_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_itm  (in_itm),
    .q_cmd   (q_cmd),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  llrb_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_cmd   (q_cmd),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .out_itm (out_itm)
  );

  `LLRB_CHECK(a_line_body_no_nl, out_itm.valid && out_itm.has_byte && !out_itm.last, out_itm.out_byte != NL, "line byte before the end is a newline")
  `LLRB_CHECK(a_line_ends_nl, out_itm.valid && out_itm.has_byte && out_itm.last, out_itm.out_byte == NL, "line does not end in a newline")
  `LLRB_CHECK(a_status_only_last, out_itm.valid && !out_itm.has_byte, out_itm.last && out_itm.out_byte == 8'h00, "status item is not a single final item")
  `LLRB_CHECK(a_byte_ok, out_itm.valid && out_itm.has_byte, out_itm.status == STS_OK, "line byte with a failure status")
endmodule

// ----- rtl/llrb_ram.sv -----
// Generic single write port RAM with a registered read port.
`timescale 1ns / 1ps
module llrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- rtl/llrb_front.sv -----
// Front end: accepts command items, classifies them and queues them.
`timescale 1ns / 1ps
module llrb_front (
  input  logic          clk,
  input  logic          rst_n,
  llrb_in_if.sink       in_itm,
  output llrb_pkg::cmd_t q_cmd,
  output logic          q_valid,
  input  logic          q_pop
);
  import llrb_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       cls;
  logic       push;
  logic       pop;

  // Clamp the length and flag slots beyond the reader table.
  always_comb begin
    cls.op       = op_e'(in_itm.operation);
    cls.data     = in_itm.data_byte;
    cls.reader   = in_itm.reader;
    cls.slot_bad = (32'(in_itm.reader) >= NUM_READERS);
    cls.limit    = (32'(in_itm.max_len) > MAX_READ) ? LEN_W'(MAX_READ) : in_itm.max_len;
  end

  assign in_itm.ready = (cnt_r != 2'd2);
  assign push         = in_itm.valid && in_itm.ready;
  assign pop          = q_pop && q_valid;
  assign q_valid      = (cnt_r != 2'd0);
  assign q_cmd        = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end
endmodule

// ----- rtl/llrb_back.sv -----
// Back end: owns the ring and reader state and executes queued commands.
`timescale 1ns / 1ps
module llrb_back (
  input  logic           clk,
  input  logic           rst_n,
  input  llrb_pkg::cmd_t q_cmd,
  input  logic           q_valid,
  output logic           q_pop,
  llrb_out_if.source     out_itm
);
  import llrb_pkg::*;

  bk_state_e        state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [CNT_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] pos_r [NUM_READERS];
  logic [CNT_W-1:0] pos_nxt [NUM_READERS];
  logic             open_r [NUM_READERS];
  logic             open_nxt [NUM_READERS];
  logic [CNT_W-1:0] cur_r, cur_nxt;
  logic [LEN_W-1:0] n_r, n_nxt;
  sts_e             sts_r, sts_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic [2:0]       out_sts_r, out_sts_nxt;
  logic             out_has_r, out_has_nxt;
  logic             out_last_r, out_last_nxt;

  logic              we, re;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata;
  logic [SLOT_W-1:0] slot;
  logic              can_emit;
  logic [CNT_W-1:0]  cur_inc;
  logic [LEN_W-1:0]  n_inc;

  llrb_ram #(.WIDTH(8), .DEPTH(LOG_SIZE)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (tail_r[ADDR_W-1:0]),
    .wdata (cmd_r.data),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign slot     = cmd_r.reader[SLOT_W-1:0];
  assign can_emit = !out_valid_r || out_itm.ready;
  assign cur_inc  = cur_r + CNT_W'(1);
  assign n_inc    = n_r + LEN_W'(1);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    pos_nxt       = pos_r;
    open_nxt      = open_r;
    cur_nxt       = cur_r;
    n_nxt         = n_r;
    sts_nxt       = sts_r;
    q_pop         = 1'b0;
    we            = 1'b0;
    re            = 1'b0;
    raddr         = head_r[ADDR_W-1:0];
    out_valid_nxt = out_valid_r && !out_itm.ready;
    out_byte_nxt  = out_byte_r;
    out_sts_nxt   = out_sts_r;
    out_has_nxt   = out_has_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_cmd;
          state_nxt = BK_DISPATCH;
        end
      end
      BK_DISPATCH: begin
        state_nxt = BK_RESULT;
        sts_nxt   = STS_OK;
        if (cmd_r.op == OP_WRITE) begin
          we       = 1'b1;
          tail_nxt = tail_r + CNT_W'(1);
          // Reaching a full ring evicts one whole line from the head.
          if ((tail_r + CNT_W'(1) - head_r) == CNT_W'(LOG_SIZE)) begin
            state_nxt = BK_EVICT_RD;
          end
        end else if (cmd_r.slot_bad) begin
          sts_nxt = STS_NO_READER;
        end else begin
          case (cmd_r.op)
            OP_OPEN: begin
              if (open_r[slot]) begin
                sts_nxt = STS_ALREADY_OPEN;
              end else begin
                open_nxt[slot] = 1'b1;
                pos_nxt[slot]  = head_r;
              end
            end
            OP_CLOSE: begin
              open_nxt[slot] = 1'b0;
            end
            OP_READ: begin
              if (!open_r[slot]) begin
                sts_nxt = STS_NO_READER;
              end else if ((tail_r - pos_r[slot]) > (tail_r - head_r)) begin
                pos_nxt[slot] = head_r;
                sts_nxt       = STS_LOST;
              end else if (cmd_r.limit == '0) begin
                sts_nxt = STS_EMPTY;
              end else begin
                cur_nxt   = pos_r[slot];
                n_nxt     = '0;
                state_nxt = BK_RD_ISSUE;
              end
            end
            default: begin
              sts_nxt = STS_OK;
            end
          endcase
        end
      end
      BK_EVICT_RD: begin
        re        = 1'b1;
        raddr     = head_r[ADDR_W-1:0];
        state_nxt = BK_EVICT_CHK;
      end
      BK_EVICT_CHK: begin
        head_nxt = head_r + CNT_W'(1);
        if (rdata == NL || rdata == NUL || (head_r + CNT_W'(1)) == tail_r) begin
          sts_nxt   = STS_OK;
          state_nxt = BK_RESULT;
        end else begin
          state_nxt = BK_EVICT_RD;
        end
      end
      BK_RD_ISSUE: begin
        // Only the first byte of a line can find the reader at the tail.
        if (cur_r == tail_r) begin
          pos_nxt[slot] = cur_r;
          sts_nxt       = STS_EMPTY;
          state_nxt     = BK_RESULT;
        end else begin
          re        = 1'b1;
          raddr     = cur_r[ADDR_W-1:0];
          state_nxt = BK_RD_DATA;
        end
      end
      BK_RD_DATA: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_sts_nxt   = STS_OK;
          out_has_nxt   = 1'b1;
          if (rdata == NL || rdata == NUL) begin
            out_byte_nxt  = NL;
            out_last_nxt  = 1'b1;
            pos_nxt[slot] = cur_inc;
            state_nxt     = BK_IDLE;
          end else if (n_inc == cmd_r.limit) begin
            // A full line ends in a newline that replaces its last byte,
            // and that byte is read again by the next read.
            out_byte_nxt  = NL;
            out_last_nxt  = 1'b1;
            pos_nxt[slot] = cur_r;
            state_nxt     = BK_IDLE;
          end else if (cur_inc == tail_r) begin
            out_byte_nxt  = rdata;
            out_last_nxt  = 1'b0;
            pos_nxt[slot] = cur_inc;
            state_nxt     = BK_EMIT_NL;
          end else begin
            out_byte_nxt = rdata;
            out_last_nxt = 1'b0;
            cur_nxt      = cur_inc;
            n_nxt        = n_inc;
            state_nxt    = BK_RD_ISSUE;
          end
        end
      end
      BK_EMIT_NL: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = NL;
          out_sts_nxt   = STS_OK;
          out_has_nxt   = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = BK_IDLE;
        end
      end
      BK_RESULT: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = 8'h00;
          out_sts_nxt   = sts_r;
          out_has_nxt   = 1'b0;
          out_last_nxt  = 1'b1;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_READERS; i++) begin
        pos_r[i]  <= '0;
        open_r[i] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      open_r      <= open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    cur_r      <= cur_nxt;
    n_r        <= n_nxt;
    sts_r      <= sts_nxt;
    out_byte_r <= out_byte_nxt;
    out_sts_r  <= out_sts_nxt;
    out_has_r  <= out_has_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_itm.valid    = out_valid_r;
  assign out_itm.out_byte = out_byte_r;
  assign out_itm.status   = out_sts_r;
  assign out_itm.has_byte = out_has_r;
  assign out_itm.last     = out_last_r;
endmodule
